### rtl/core/assert_macros.svh
// assert_macros.svh: assertion macros for the planar UV fit core.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/tpuv_pkg.sv
// tpuv_pkg: shared constants and payload types of the planar UV fit core.
// No dependencies; imported by tpuv_pipe and triangle_planar_uv_fit_core.
package tpuv_pkg;

  localparam int COORD_W = 32;
  localparam int THR_W   = 16;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  // Register index lives in paddr bit 2 (word addressing).
  localparam int   CFG_IDX_LSB = 2;
  localparam logic CFG_IDX_THR = 1'b0;

  localparam logic [THR_W-1:0]   THR_RESET = 16'd1;
  localparam logic [COORD_W-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [COORD_W-1:0] Q_SAT     = 32'h7FFF_FFFF;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic signed [COORD_W-1:0] third_x;
    logic signed [COORD_W-1:0] third_y;
    logic signed [COORD_W-1:0] third_z;
  } vtx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] scale_u;
    logic signed [COORD_W-1:0] scale_v;
    logic signed [COORD_W-1:0] ofs_u;
    logic signed [COORD_W-1:0] ofs_v;
    logic                      degenerate;
  } res_t;

endpackage

### rtl/core/tpuv_pipe.sv
// tpuv_pipe: datapath pipeline of the planar UV fit core.
// Depends on tpuv_pkg; instantiated by triangle_planar_uv_fit_core.
module tpuv_pipe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vtx_valid,
  input  tpuv_pkg::vtx_t                vtx,
  input  logic [tpuv_pkg::THR_W-1:0]    thr,
  output logic                          res_valid,
  output tpuv_pkg::res_t                res
);
  import tpuv_pkg::*;

  localparam int FRONT       = 7;
  localparam int DIV_STEPS   = 66;
  localparam int SQ_STEPS    = 33;
  localparam int RD_STEPS    = 33;
  localparam int PIPE_STAGES = FRONT + DIV_STEPS + SQ_STEPS + 1 + RD_STEPS + 1;

  typedef struct packed {
    logic [132:0] acc_d;
    logic [132:0] acc_n;
    logic [65:0]  s1;
    logic         dneg;
    logic         degn;
  } div_st_t;

  typedef struct packed {
    logic [65:0] x;
    logic [35:0] rem;
    logic [32:0] root;
  } sq_unit_t;

  typedef struct packed {
    sq_unit_t ul;
    sq_unit_t ut;
    sq_unit_t uh;
    logic     dneg;
    logic     degn;
  } sq_st_t;

  typedef struct packed {
    logic [67:0] acc_su;
    logic [67:0] acc_sv;
    logic [67:0] acc_of;
    logic [33:0] rng;
    logic [33:0] hv;
    logic        dneg;
    logic        deg;
  } rd_st_t;

  // One restoring division step: 66-bit divisor, 67-bit partial remainder.
  function automatic logic [132:0] big_step(input logic [132:0] acc,
                                            input logic [65:0] dvs);
    logic [132:0] sh;
    logic [66:0]  u;
    logic         q;
    sh = {acc[131:0], 1'b0};
    u  = sh[132:66];
    q  = (u >= {1'b0, dvs});
    if (q) begin
      u = u - {1'b0, dvs};
    end
    return {u, sh[65:1], q};
  endfunction

  // One restoring division step: 34-bit divisor, 35-bit partial remainder.
  function automatic logic [67:0] small_step(input logic [67:0] acc,
                                             input logic [33:0] dvs);
    logic [67:0] sh;
    logic [34:0] u;
    logic        q;
    sh = {acc[66:0], 1'b0};
    u  = sh[67:33];
    q  = (u >= {1'b0, dvs});
    if (q) begin
      u = u - {1'b0, dvs};
    end
    return {u, sh[32:1], q};
  endfunction

  // One digit of the integer square root, two radicand bits per step.
  function automatic sq_unit_t sq_step(input sq_unit_t u);
    logic [35:0] rem2;
    logic [35:0] trial;
    sq_unit_t    o;
    rem2 = {u.rem[33:0], u.x[65:64]};
    trial = {1'b0, u.root, 2'b01};
    o.x = {u.x[63:0], 2'b00};
    if (rem2 >= trial) begin
      o.rem  = rem2 - trial;
      o.root = {u.root[31:0], 1'b1};
    end else begin
      o.rem  = rem2;
      o.root = {u.root[31:0], 1'b0};
    end
    return o;
  endfunction

  logic [PIPE_STAGES-1:0] vld_r, vld_nxt;

  // Front stages.
  logic signed [32:0] e1_r [3], e1_nxt [3];
  logic signed [32:0] e2_r [3], e2_nxt [3];
  logic signed [65:0] sqp_r [3], sqp_nxt [3];
  logic signed [65:0] dp_r [3], dp_nxt [3];
  logic signed [65:0] na_r [3], na_nxt [3];
  logic signed [65:0] nb_r [3], nb_nxt [3];
  logic [65:0]        s1_3_r, s1_3_nxt;
  logic signed [67:0] d3_r, d3_nxt;
  logic signed [66:0] n3_r [3], n3_nxt [3];
  logic [65:0]        s1_4_r, s1_4_nxt;
  logic               dneg_4_r, dneg_4_nxt;
  logic [65:0]        mag_r [4], mag_nxt [4];
  logic [65:0]        s1_5_r;
  logic               dneg_5_r;
  logic [65:0]        hh_r [4], hh_nxt [4];
  logic [65:0]        hl_r [4], hl_nxt [4];
  logic [65:0]        ll_r [4], ll_nxt [4];
  logic [65:0]        s1_6_r;
  logic               dneg_6_r;
  logic [131:0]       sqr_r [4], sqr_nxt [4];
  logic [65:0]        s1_7_r;
  logic               dneg_7_r;
  logic [131:0]       nn_r, nn_nxt;
  logic [131:0]       d2_r;

  div_st_t div_r [DIV_STEPS], div_nxt [DIV_STEPS];
  sq_st_t  sq_r [SQ_STEPS], sq_nxt [SQ_STEPS];
  rd_st_t  rd_r [RD_STEPS], rd_nxt [RD_STEPS];

  logic [33:0] rng_r, rng_nxt;
  logic [32:0] h_r, h_nxt;
  logic [32:0] tm_r, tm_nxt;
  logic        dneg_r_r, deg_r_r, deg_r_nxt;
  res_t        fin_r, fin_nxt;

  logic [31:0] thr_sq;

  assign vld_nxt = {vld_r[PIPE_STAGES-2:0], vtx_valid};
  assign thr_sq  = {16'd0, thr} * {16'd0, thr};

  always_comb begin
    // Edge vectors relative to the first vertex.
    e1_nxt[0] = {vtx.second_x[31], vtx.second_x} - {vtx.first_x[31], vtx.first_x};
    e1_nxt[1] = {vtx.second_y[31], vtx.second_y} - {vtx.first_y[31], vtx.first_y};
    e1_nxt[2] = {vtx.second_z[31], vtx.second_z} - {vtx.first_z[31], vtx.first_z};
    e2_nxt[0] = {vtx.third_x[31], vtx.third_x} - {vtx.first_x[31], vtx.first_x};
    e2_nxt[1] = {vtx.third_y[31], vtx.third_y} - {vtx.first_y[31], vtx.first_y};
    e2_nxt[2] = {vtx.third_z[31], vtx.third_z} - {vtx.first_z[31], vtx.first_z};

    for (int k = 0; k < 3; k++) begin
      sqp_nxt[k] = e1_r[k] * e1_r[k];
      dp_nxt[k]  = e1_r[k] * e2_r[k];
    end
    // Cross product terms: N = E1 x E2.
    na_nxt[0] = e1_r[1] * e2_r[2];
    nb_nxt[0] = e1_r[2] * e2_r[1];
    na_nxt[1] = e1_r[2] * e2_r[0];
    nb_nxt[1] = e1_r[0] * e2_r[2];
    na_nxt[2] = e1_r[0] * e2_r[1];
    nb_nxt[2] = e1_r[1] * e2_r[0];

    s1_3_nxt = $unsigned(sqp_r[0]) + $unsigned(sqp_r[1]) + $unsigned(sqp_r[2]);
    d3_nxt   = dp_r[0] + dp_r[1] + dp_r[2];
    for (int k = 0; k < 3; k++) begin
      n3_nxt[k] = na_r[k] - nb_r[k];
    end
  end

  always_comb begin : b_mag
    logic signed [67:0] dabs;
    logic signed [66:0] nabs;
    s1_4_nxt   = s1_3_r;
    dneg_4_nxt = d3_r[67];
    dabs       = d3_r[67] ? -d3_r : d3_r;
    mag_nxt[0] = dabs[65:0];
    for (int k = 0; k < 3; k++) begin
      nabs           = n3_r[k][66] ? -n3_r[k] : n3_r[k];
      mag_nxt[k + 1] = nabs[65:0];
    end
  end

  // Squares of the 66-bit magnitudes are built from 33-bit halves.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hh_nxt[k]  = mag_r[k][65:33] * mag_r[k][65:33];
      hl_nxt[k]  = mag_r[k][65:33] * mag_r[k][32:0];
      ll_nxt[k]  = mag_r[k][32:0] * mag_r[k][32:0];
      sqr_nxt[k] = {hh_r[k], 66'd0} + {32'd0, hl_r[k], 34'd0} + {66'd0, ll_r[k]};
    end
    nn_nxt = sqr_r[1] + sqr_r[2] + sqr_r[3];
  end

  // Long division d^2 / |E1|^2 and |N|^2 / |E1|^2, one quotient bit per stage.
  always_comb begin : b_div
    div_st_t init;
    init.acc_d = {1'b0, d2_r};
    init.acc_n = {1'b0, nn_r};
    init.s1    = s1_7_r;
    init.dneg  = dneg_7_r;
    init.degn  = (nn_r == '0) || (nn_r < {68'd0, thr_sq, 32'd0});
    for (int k = 0; k < DIV_STEPS; k++) begin
      div_nxt[k] = (k == 0) ? init : div_r[(k == 0) ? 0 : k - 1];
      div_nxt[k].acc_d = big_step(div_nxt[k].acc_d, div_nxt[k].s1);
      div_nxt[k].acc_n = big_step(div_nxt[k].acc_n, div_nxt[k].s1);
    end
  end

  // Square roots of |E1|^2 and of both quotients run side by side.
  always_comb begin : b_sqrt
    sq_st_t init;
    init.ul.x    = div_r[DIV_STEPS-1].s1;
    init.ut.x    = div_r[DIV_STEPS-1].acc_d[65:0];
    init.uh.x    = div_r[DIV_STEPS-1].acc_n[65:0];
    init.ul.rem  = '0;
    init.ut.rem  = '0;
    init.uh.rem  = '0;
    init.ul.root = '0;
    init.ut.root = '0;
    init.uh.root = '0;
    init.dneg    = div_r[DIV_STEPS-1].dneg;
    init.degn    = div_r[DIV_STEPS-1].degn;
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_nxt[k]    = (k == 0) ? init : sq_r[(k == 0) ? 0 : k - 1];
      sq_nxt[k].ul = sq_step(sq_nxt[k].ul);
      sq_nxt[k].ut = sq_step(sq_nxt[k].ut);
      sq_nxt[k].uh = sq_step(sq_nxt[k].uh);
    end
  end

  // U extent spans both ends of the first edge and the projected third vertex.
  always_comb begin : b_range
    logic [32:0] len;
    len    = sq_r[SQ_STEPS-1].ul.root;
    tm_nxt = sq_r[SQ_STEPS-1].ut.root;
    h_nxt  = sq_r[SQ_STEPS-1].uh.root;
    if (sq_r[SQ_STEPS-1].dneg) begin
      rng_nxt = {1'b0, len} + {1'b0, tm_nxt};
    end else begin
      rng_nxt = (tm_nxt > len) ? {1'b0, tm_nxt} : {1'b0, len};
    end
    deg_r_nxt = sq_r[SQ_STEPS-1].degn || (rng_nxt == '0) || (h_nxt == '0) ||
                (rng_nxt < {18'd0, thr}) || (h_nxt < {17'd0, thr});
  end

  // Reciprocals of both extents and the U offset ratio.
  always_comb begin : b_recip
    rd_st_t init;
    init.acc_su = {35'd0, 33'h1_0000_0000};
    init.acc_sv = {35'd0, 33'h1_0000_0000};
    init.acc_of = {19'd0, tm_r[32:17], tm_r[16:0], 16'd0};
    init.rng    = rng_r;
    init.hv     = {1'b0, h_r};
    init.dneg   = dneg_r_r;
    init.deg    = deg_r_r;
    for (int k = 0; k < RD_STEPS; k++) begin
      rd_nxt[k]        = (k == 0) ? init : rd_r[(k == 0) ? 0 : k - 1];
      rd_nxt[k].acc_su = small_step(rd_nxt[k].acc_su, rd_nxt[k].rng);
      rd_nxt[k].acc_sv = small_step(rd_nxt[k].acc_sv, rd_nxt[k].hv);
      rd_nxt[k].acc_of = small_step(rd_nxt[k].acc_of, rd_nxt[k].rng);
    end
  end

  always_comb begin : b_final
    logic [32:0] qu;
    logic [32:0] qv;
    qu = rd_r[RD_STEPS-1].acc_su[32:0];
    qv = rd_r[RD_STEPS-1].acc_sv[32:0];
    if (rd_r[RD_STEPS-1].deg) begin
      fin_nxt.scale_u    = Q_ONE;
      fin_nxt.scale_v    = Q_ONE;
      fin_nxt.ofs_u      = '0;
      fin_nxt.ofs_v      = '0;
      fin_nxt.degenerate = 1'b1;
    end else begin
      fin_nxt.scale_u    = (qu > {1'b0, Q_SAT}) ? Q_SAT : qu[31:0];
      fin_nxt.scale_v    = (qv > {1'b0, Q_SAT}) ? Q_SAT : qv[31:0];
      fin_nxt.ofs_u      = rd_r[RD_STEPS-1].dneg ? rd_r[RD_STEPS-1].acc_of[31:0] : '0;
      fin_nxt.ofs_v      = '0;
      fin_nxt.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r     <= e1_nxt;
      e2_r     <= e2_nxt;
      sqp_r    <= sqp_nxt;
      dp_r     <= dp_nxt;
      na_r     <= na_nxt;
      nb_r     <= nb_nxt;
      s1_3_r   <= s1_3_nxt;
      d3_r     <= d3_nxt;
      n3_r     <= n3_nxt;
      s1_4_r   <= s1_4_nxt;
      dneg_4_r <= dneg_4_nxt;
      mag_r    <= mag_nxt;
      s1_5_r   <= s1_4_r;
      dneg_5_r <= dneg_4_r;
      hh_r     <= hh_nxt;
      hl_r     <= hl_nxt;
      ll_r     <= ll_nxt;
      s1_6_r   <= s1_5_r;
      dneg_6_r <= dneg_5_r;
      sqr_r    <= sqr_nxt;
      s1_7_r   <= s1_6_r;
      dneg_7_r <= dneg_6_r;
      nn_r     <= nn_nxt;
      d2_r     <= sqr_r[0];
      div_r    <= div_nxt;
      sq_r     <= sq_nxt;
      rng_r    <= rng_nxt;
      h_r      <= h_nxt;
      tm_r     <= tm_nxt;
      dneg_r_r <= sq_r[SQ_STEPS-1].dneg;
      deg_r_r  <= deg_r_nxt;
      rd_r     <= rd_nxt;
      fin_r    <= fin_nxt;
    end
  end

  assign res_valid = vld_r[PIPE_STAGES-1];
  assign res       = fin_r;

endmodule

### rtl/core/triangle_planar_uv_fit_core.sv
// triangle_planar_uv_fit_core: top level of the planar UV fit core.
// Depends on tpuv_pkg, tpuv_pipe and assert_macros.svh.
//
// Usage: one triangle (three vertices, signed Q16.16) enters on the in_
// channel as a valid/ready transaction; one result transaction leaves on the
// out_ channel with U/V scale, U/V offset (Q16.16) and a degenerate flag.
// The threshold register sits at byte address 0 of the APB-style port and
// should only be written while no transaction is in flight.
// Throughput: one transaction per cycle while the output is not stalled.
// The pipeline depth is set mainly by the 66-step long division of the squared
// dot product and normal length by the squared first-edge length, followed by
// a 33-step square root and a 33-step reciprocal divider.
// Reset: rst_n is synchronous; it empties the pipeline, the output register
// and the skid register, and sets the threshold to 1 (raw Q16.16 units).
// Stall: when out_ready is low, one more finished transaction is caught in a
// skid register; in_ready then drops and the whole pipeline holds.
`include "assert_macros.svh"

module triangle_planar_uv_fit_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tpuv_pkg::COORD_W-1:0] in_first_x,
  input  logic signed [tpuv_pkg::COORD_W-1:0] in_first_y,
  input  logic signed [tpuv_pkg::COORD_W-1:0] in_first_z,
  input  logic signed [tpuv_pkg::COORD_W-1:0] in_second_x,
  input  logic signed [tpuv_pkg::COORD_W-1:0] in_second_y,
  input  logic signed [tpuv_pkg::COORD_W-1:0] in_second_z,
  input  logic signed [tpuv_pkg::COORD_W-1:0] in_third_x,
  input  logic signed [tpuv_pkg::COORD_W-1:0] in_third_y,
  input  logic signed [tpuv_pkg::COORD_W-1:0] in_third_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tpuv_pkg::COORD_W-1:0] out_scale_u_out,
  output logic signed [tpuv_pkg::COORD_W-1:0] out_scale_v_out,
  output logic signed [tpuv_pkg::COORD_W-1:0] out_offset_u_out,
  output logic signed [tpuv_pkg::COORD_W-1:0] out_offset_v_out,
  output logic                                out_degenerate,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tpuv_pkg::CFG_AW-1:0]         paddr,
  input  logic [tpuv_pkg::CFG_DW-1:0]         pwdata,
  output logic [tpuv_pkg::CFG_DW-1:0]         prdata,
  output logic                                pready
);
  import tpuv_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic             cfg_wr;

  vtx_t vtx;
  logic pipe_en;
  logic res_valid;
  res_t res;

  res_t out_r, out_nxt;
  logic out_v_r, out_v_nxt;
  res_t skid_r, skid_nxt;
  logic skid_v_r, skid_v_nxt;

  // Configuration port: zero wait states, write in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[CFG_IDX_LSB] == CFG_IDX_THR) ? {16'd0, thr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr && (paddr[CFG_IDX_LSB] == CFG_IDX_THR)) begin
      thr_r <= pwdata[THR_W-1:0];
    end
  end

  assign vtx.first_x  = in_first_x;
  assign vtx.first_y  = in_first_y;
  assign vtx.first_z  = in_first_z;
  assign vtx.second_x = in_second_x;
  assign vtx.second_y = in_second_y;
  assign vtx.second_z = in_second_z;
  assign vtx.third_x  = in_third_x;
  assign vtx.third_y  = in_third_y;
  assign vtx.third_z  = in_third_z;

  // The pipeline advances as long as the skid register is free; an empty
  // skid register guarantees room for whatever leaves the last stage.
  assign pipe_en  = !skid_v_r;
  assign in_ready = pipe_en;

  tpuv_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .vtx_valid (in_valid),
    .vtx       (vtx),
    .thr       (thr_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register plus one skid entry.
  always_comb begin
    logic slot_free;
    slot_free  = !out_v_r || out_ready;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r && !out_ready;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (slot_free) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (slot_free) begin
        out_nxt   = res;
        out_v_nxt = 1'b1;
      end else begin
        skid_nxt   = res;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_v_r;
  assign out_scale_u_out  = out_r.scale_u;
  assign out_scale_v_out  = out_r.scale_v;
  assign out_offset_u_out = out_r.ofs_u;
  assign out_offset_v_out = out_r.ofs_v;
  assign out_degenerate   = out_r.degenerate;

  // The skid register only ever holds a transaction behind a full output.
  `ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_v_r, out_v_r, "skid full, output empty")
  // The skid register fills only when the output was stalled.
  `ASSERT_IMPLY(a_skid_fill_on_stall, clk, rst_n, $rose(skid_v_r), $past(out_v_r && !out_ready), "skid filled without stall")
  // A degenerate triangle always carries the default mapping.
  `ASSERT_IMPLY(a_deg_default, clk, rst_n, out_v_r && out_r.degenerate, (out_r.scale_u == Q_ONE) && (out_r.scale_v == Q_ONE) && (out_r.ofs_u == '0), "degenerate result not default")
  // The V minimum sits at the first vertex, so the V offset is always zero.
  `ASSERT_ALWAYS(a_ofs_v_zero, clk, rst_n, !out_v_r || (out_r.ofs_v == '0), "nonzero V offset")

endmodule
